@@ hw/rtl/rbr_pkg.sv @@
// Shared types and constants of the refcounted buffer recycler.
`default_nettype none

package rbr_pkg;

   // Fixed field widths of the request and response beats
   localparam int CMD_W    = 1;
   localparam int CHAN_W   = 2;
   localparam int IDX_W    = 2;
   localparam int WORDS_W  = 13;
   localparam int CNT_W    = 2;
   localparam int CHANNELS = 4;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_FILL = 1'b0;
   localparam logic [CMD_W-1:0] CMD_DONE = 1'b1;

   // Use count given to a freshly filled buffer (one per queue)
   localparam logic [CNT_W-1:0] INITIAL_USES = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [CHAN_W-1:0]  channel;
      logic [IDX_W-1:0]   buffer_index;
      logic [WORDS_W-1:0] buffer_words;
   } req_type;

   typedef struct packed {
      logic               push_accepted;
      logic [IDX_W-1:0]   next_buffer;
      logic [WORDS_W-1:0] next_words;
      logic               underflow;
      logic               released;
      logic [IDX_W-1:0]   released_buffer;
   } rsp_type;

   // One entry of the buffer table memory
   typedef struct packed {
      logic [CNT_W-1:0]   cnt;
      logic [WORDS_W-1:0] words;
   } bentry_type;

   localparam int BENTRY_W = $bits(bentry_type);

endpackage

`default_nettype wire

@@ hw/rtl/refcounted_buffer_recycler.sv @@
// Top level of the refcounted buffer recycler: memories, sequencer, output register.
`default_nettype none

// Each request beat is either a producer fill (buffer index and length) or a
// channel completion; each yields exactly one response beat. An accepted fill
// passes the check state, which pushes onto the first queue, and the second
// queue push state before its response is loaded into the output register (a
// refused fill skips the pushes), and a completion passes the check and length
// states: the sequencer reads the buffer table and queue slot memories, each
// with registered read data, modifies and writes back, and a completion needs
// a second buffer table read for the next buffer's length. The sequencer is
// ready again the cycle after the load. One request is in flight at a time; a
// new request is taken while the previous response still waits in the output
// register, and a response that cannot be loaded because that register is
// still full stalls the sequencer and the request side. Both memories hold no
// state at reset; use counts and channel bindings are cleared at once.

module refcounted_buffer_recycler
   import rbr_pkg::*;
#(
   parameter int BUFFERS     = 4,
   parameter int QUEUE_DEPTH = 8,
   parameter int MAX_WORDS   = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int BIDX_W      = $clog2(BUFFERS);
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QRAM_DEPTH  = 2 * (1 << PTR_W);

   logic              qram_we;
   logic [PTR_W:0]    qram_waddr;
   logic [IDX_W-1:0]  qram_wdata;
   logic [PTR_W:0]    qram_raddr;
   logic [IDX_W-1:0]  qram_rdata;
   logic              bram_we;
   logic [BIDX_W-1:0] bram_waddr;
   bentry_type        bram_wdata;
   logic [BIDX_W-1:0] bram_raddr;
   bentry_type        bram_rdata;
   logic              rsp_free;
   logic              res_load;
   rsp_type           res_data;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;

   // Slots of both ring queues, queue number as the top address bit
   rbr_ram #(
      .WIDTH (IDX_W),
      .DEPTH (QRAM_DEPTH)
   ) u_qram (
      .clock   (clock),
      .wr_en   (qram_we),
      .wr_addr (qram_waddr),
      .wr_data (qram_wdata),
      .rd_addr (qram_raddr),
      .rd_data (qram_rdata)
   );

   // Buffer table: use count and length per buffer
   rbr_ram #(
      .WIDTH (BENTRY_W),
      .DEPTH (BUFFERS)
   ) u_bram (
      .clock   (clock),
      .wr_en   (bram_we),
      .wr_addr (bram_waddr),
      .wr_data (bram_wdata),
      .rd_addr (bram_raddr),
      .rd_data (bram_rdata)
   );

   rbr_ctrl #(
      .BUFFERS     (BUFFERS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MAX_WORDS   (MAX_WORDS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_free   (rsp_free),
      .res_load   (res_load),
      .res_data   (res_data),
      .qram_we    (qram_we),
      .qram_waddr (qram_waddr),
      .qram_wdata (qram_wdata),
      .qram_raddr (qram_raddr),
      .qram_rdata (qram_rdata),
      .bram_we    (bram_we),
      .bram_waddr (bram_waddr),
      .bram_wdata (bram_wdata),
      .bram_raddr (bram_raddr),
      .bram_rdata (bram_rdata)
   );

   // Response output register
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/rbr_ram.sv @@
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module rbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read (read returns old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/rbr_ctrl.sv @@
// Sequencer: read-modify-write of the buffer table and the two ring queues.
`default_nettype none

module rbr_ctrl
   import rbr_pkg::*;
#(
   parameter int BUFFERS     = 4,
   parameter int QUEUE_DEPTH = 8,
   parameter int MAX_WORDS   = 4096,
   localparam int BIDX_W     = $clog2(BUFFERS),
   localparam int PTR_W      = $clog2(QUEUE_DEPTH)
) (
   input  logic               clock,
   input  logic               reset,
   // request side
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_data,
   // result hand-off to the output register
   input  logic               rsp_free,
   output logic               res_load,
   output rsp_type            res_data,
   // queue slot memory
   output logic               qram_we,
   output logic [PTR_W:0]     qram_waddr,
   output logic [IDX_W-1:0]   qram_wdata,
   output logic [PTR_W:0]     qram_raddr,
   input  logic [IDX_W-1:0]   qram_rdata,
   // buffer table memory
   output logic               bram_we,
   output logic [BIDX_W-1:0]  bram_waddr,
   output bentry_type         bram_wdata,
   output logic [BIDX_W-1:0]  bram_raddr,
   input  bentry_type         bram_rdata
);

   typedef enum logic [5:0] {
      ST_IDLE       = 6'b000001,
      ST_FILL_CHECK = 6'b000010,
      ST_FILL_PUSH2 = 6'b000100,
      ST_DONE_CHECK = 6'b001000,
      ST_DONE_LEN   = 6'b010000,
      ST_RESULT     = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   req_type             item_ff, item_in;
   rsp_type             res_ff, res_in;
   logic [PTR_W-1:0]    head_ff [2];
   logic [PTR_W-1:0]    head_in [2];
   logic [PTR_W-1:0]    tail_ff [2];
   logic [PTR_W-1:0]    tail_in [2];
   logic [CHANNELS-1:0] chan_valid_ff, chan_valid_in;
   logic [IDX_W-1:0]    chan_idx_ff [CHANNELS];
   logic [IDX_W-1:0]    chan_idx_in [CHANNELS];
   logic [BUFFERS-1:0]  cnt_valid_ff, cnt_valid_in;

   logic [CHAN_W-1:0]   sel_ch;
   logic                sel_q;
   logic                had;
   logic [IDX_W-1:0]    fin;
   logic                q_empty;
   logic                full0, full1;
   logic [BIDX_W-1:0]   vb_addr;
   logic [CNT_W-1:0]    cnt_cur;
   logic [IDX_W-1:0]    next_sel;
   logic                fill_ok;
   logic [WORDS_W-1:0]  words_clamped;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (32'(p) == QUEUE_DEPTH - 1) begin
         r = '0;
      end else begin
         r = PTR_W'(p + 1'b1);
      end
      return r;
   endfunction

   // Lookups shared by all states
   always_comb begin
      sel_ch   = (state_ff == ST_IDLE) ? req_data.channel : item_ff.channel;
      sel_q    = sel_ch[CHAN_W-1];
      had      = chan_valid_ff[sel_ch];
      fin      = chan_idx_ff[sel_ch];
      q_empty  = (head_ff[sel_q] == tail_ff[sel_q]);
      full0    = (ring_next(tail_ff[0]) == head_ff[0]);
      full1    = (ring_next(tail_ff[1]) == head_ff[1]);
      vb_addr  = (state_ff == ST_FILL_CHECK) ? BIDX_W'(item_ff.buffer_index)
                                             : BIDX_W'(fin);
      cnt_cur  = cnt_valid_ff[vb_addr] ? bram_rdata.cnt : '0;
      if (q_empty) begin
         next_sel = had ? fin : '0;
      end else begin
         next_sel = qram_rdata;
      end
      fill_ok  = (32'(item_ff.buffer_index) < BUFFERS) && (cnt_cur == '0) &&
                 !full0 && !full1;
      words_clamped = (32'(item_ff.buffer_words) > MAX_WORDS) ? WORDS_W'(MAX_WORDS)
                                                              : item_ff.buffer_words;
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      res_in        = res_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      chan_valid_in = chan_valid_ff;
      chan_idx_in   = chan_idx_ff;
      cnt_valid_in  = cnt_valid_ff;
      req_ready     = 1'b0;
      res_load      = 1'b0;
      qram_we       = 1'b0;
      qram_waddr    = '0;
      qram_wdata    = '0;
      qram_raddr    = {sel_q, head_ff[sel_q]};
      bram_we       = 1'b0;
      bram_waddr    = '0;
      bram_wdata    = '0;
      bram_raddr    = BIDX_W'(fin);

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_data.command == CMD_FILL) begin
               bram_raddr = BIDX_W'(req_data.buffer_index);
            end
            if (req_valid) begin
               item_in = req_data;
               res_in  = '0;
               state_in = (req_data.command == CMD_FILL) ? ST_FILL_CHECK
                                                         : ST_DONE_CHECK;
            end
         end
         ST_FILL_CHECK: begin
            if (fill_ok) begin
               bram_we          = 1'b1;
               bram_waddr       = BIDX_W'(item_ff.buffer_index);
               bram_wdata.cnt   = INITIAL_USES;
               bram_wdata.words = words_clamped;
               cnt_valid_in[BIDX_W'(item_ff.buffer_index)] = 1'b1;
               qram_we          = 1'b1;
               qram_waddr       = {1'b0, tail_ff[0]};
               qram_wdata       = item_ff.buffer_index;
               tail_in[0]       = ring_next(tail_ff[0]);
               res_in.push_accepted = 1'b1;
               state_in         = ST_FILL_PUSH2;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_FILL_PUSH2: begin
            qram_we    = 1'b1;
            qram_waddr = {1'b1, tail_ff[1]};
            qram_wdata = item_ff.buffer_index;
            tail_in[1] = ring_next(tail_ff[1]);
            state_in   = ST_RESULT;
         end
         ST_DONE_CHECK: begin
            // retire the finished buffer
            if (had && (cnt_cur != '0)) begin
               bram_we          = 1'b1;
               bram_waddr       = BIDX_W'(fin);
               bram_wdata.cnt   = cnt_cur - CNT_W'(1);
               bram_wdata.words = bram_rdata.words;
               if (cnt_cur == CNT_W'(1)) begin
                  res_in.released        = 1'b1;
                  res_in.released_buffer = fin;
               end
            end
            // pop the next buffer, or on underflow repeat the finished one (buffer 0 if the channel had none)
            if (!q_empty) begin
               head_in[sel_q] = ring_next(head_ff[sel_q]);
            end
            chan_valid_in[sel_ch] = 1'b1;
            chan_idx_in[sel_ch]   = next_sel;
            res_in.next_buffer    = next_sel;
            res_in.underflow      = q_empty;
            bram_raddr            = BIDX_W'(next_sel);
            state_in              = ST_DONE_LEN;
         end
         ST_DONE_LEN: begin
            res_in.next_words = bram_rdata.words;
            state_in          = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_free) begin
               res_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '{default: '0};
         tail_ff       <= '{default: '0};
         chan_valid_ff <= '0;
         cnt_valid_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         chan_valid_ff <= chan_valid_in;
         cnt_valid_ff  <= cnt_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      res_ff      <= res_in;
      chan_idx_ff <= chan_idx_in;
   end

   assign res_data = res_ff;

`ifndef SYNTHESIS
   // queue pointers stay inside the ring
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (32'(head_ff[0]) < QUEUE_DEPTH) && (32'(tail_ff[0]) < QUEUE_DEPTH) &&
      (32'(head_ff[1]) < QUEUE_DEPTH) && (32'(tail_ff[1]) < QUEUE_DEPTH))
      else $error("queue pointer out of range");

   // a push on the second queue never wraps it to look empty
   a_push_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL_PUSH2) |=> (tail_ff[1] != head_ff[1]))
      else $error("second queue appears empty after a push");

   // use counts are only ever written as 0, 1 or 2
   a_cnt_write: assert property (@(posedge clock) disable iff (reset)
      bram_we |-> (bram_wdata.cnt != 2'd3))
      else $error("illegal use count written");

   // an underflowing completion leaves both queue heads alone
   a_underflow_heads: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE_CHECK) && q_empty) |=>
      ($stable(head_ff[0]) && $stable(head_ff[1])))
      else $error("queue head moved on underflow");
`endif

endmodule

`default_nettype wire
